// File: hw/rtl/dccm_pkg.sv
// Package: shared types and constants of the decaying count-min rate meter.
`timescale 1ns / 1ps
package dccm_pkg;

   localparam int BUCKET_FIELDS = 4;
   localparam int KIDX_W        = 2;
   localparam int RATE_W        = 48;
   localparam int AMOUNT_W      = 24;
   localparam int ALPHA_W       = 16;
   localparam int SCALE_W       = 24;
   localparam int NHASH_W       = 3;
   localparam int SLOT_W        = 17;
   localparam int MUL_A_W       = 32;
   localparam int MUL_B_W       = 25;
   localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 24;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_DECAY = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NHASH = 2'd2;

   localparam logic [1:0] MSEL_RT0   = 2'd0;
   localparam logic [1:0] MSEL_T1    = 2'd1;
   localparam logic [1:0] MSEL_T2    = 2'd2;
   localparam logic [1:0] MSEL_DECAY = 2'd3;

   typedef struct packed {
      logic              capture;
      logic              rd_en;
      logic              addr_scan;
      logic [KIDX_W-1:0] k;
      logic              min_upd;
      logic              add_amt;
      logic              wr_bump;
      logic              clear_wr;
      logic              decay_wr;
      logic              scan_inc;
      logic [1:0]        mul_sel;
      logic              mul_hi;
      logic              mul_lo;
      logic              mul_sum;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       use_slot;
      logic       k_last;
      logic       scan_last;
   } dp_sts_type;

endpackage

// File: hw/rtl/dccm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dccm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/dccm_ctrl.sv
// Controller: sequences clear, lookup, update, rate arithmetic and decay sweep.
`timescale 1ns / 1ps
module dccm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  dccm_pkg::dp_sts_type sts,
   output dccm_pkg::ctl_cmd_type ctl
);
   import dccm_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DISP  = 4'd2;
   localparam logic [3:0] ST_RD    = 4'd3;
   localparam logic [3:0] ST_MIN   = 4'd4;
   localparam logic [3:0] ST_ADDA  = 4'd5;
   localparam logic [3:0] ST_BRD   = 4'd6;
   localparam logic [3:0] ST_BUMP  = 4'd7;
   localparam logic [3:0] ST_MHI   = 4'd8;
   localparam logic [3:0] ST_MLO   = 4'd9;
   localparam logic [3:0] ST_MSUM  = 4'd10;
   localparam logic [3:0] ST_DRD   = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [1:0]        sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
         sel_ff   <= MSEL_RT0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      sel_in   = sel_ff;
      ctl      = '0;
      ctl.k       = k_ff;
      ctl.mul_sel = sel_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr  = 1'b1;
            ctl.addr_scan = 1'b1;
            ctl.scan_inc  = 1'b1;
            if (sts.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               k_in        = '0;
               state_in    = ST_DISP;
            end
         end
         ST_DISP: begin
            unique case (sts.cmd) inside
               CMD_ADD, CMD_CHECK: state_in = ST_RD;
               CMD_DECAY: begin
                  sel_in   = MSEL_DECAY;
                  state_in = ST_DRD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_MIN;
         end
         ST_MIN: begin
            ctl.min_upd = 1'b1;
            if (sts.k_last) begin
               k_in = '0;
               if (sts.cmd == CMD_ADD) begin
                  state_in = ST_ADDA;
               end else begin
                  sel_in   = MSEL_RT0;
                  state_in = ST_MHI;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_ADDA: begin
            ctl.add_amt = 1'b1;
            state_in    = ST_BRD;
         end
         ST_BRD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_BUMP;
         end
         ST_BUMP: begin
            ctl.wr_bump = 1'b1;
            if (sts.k_last) begin
               sel_in   = MSEL_RT0;
               state_in = ST_MHI;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_BRD;
            end
         end
         ST_MHI: begin
            ctl.mul_hi = 1'b1;
            state_in   = ST_MLO;
         end
         ST_MLO: begin
            ctl.mul_lo = 1'b1;
            state_in   = ST_MSUM;
         end
         ST_MSUM: begin
            ctl.mul_sum = 1'b1;
            unique case (sel_ff)
               MSEL_RT0: begin
                  if (sts.use_slot) begin
                     sel_in   = MSEL_T1;
                     state_in = ST_MHI;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               MSEL_T1: begin
                  sel_in   = MSEL_T2;
                  state_in = ST_MHI;
               end
               MSEL_T2: state_in = ST_DONE;
               default: begin
                  ctl.decay_wr  = 1'b1;
                  ctl.addr_scan = 1'b1;
                  ctl.scan_inc  = 1'b1;
                  state_in      = sts.scan_last ? ST_DONE : ST_DRD;
               end
            endcase
         end
         ST_DRD: begin
            ctl.rd_en     = 1'b1;
            ctl.addr_scan = 1'b1;
            state_in      = ST_MHI;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
endmodule

// File: hw/rtl/dccm_dp.sv
// Datapath: config registers, bucket minima, shared multiplier and rate result.
`timescale 1ns / 1ps
module dccm_dp #(
   parameter int HASH_BITS    = 10,
   parameter int MAX_HASHES   = 4,
   parameter int COUNTER_BITS = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dccm_pkg::ctl_cmd_type             ctl,
   output dccm_pkg::dp_sts_type              sts,
   input  logic                              csr_wr_en,
   input  logic [dccm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dccm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [1:0]                        req_cmd,
   input  logic [9:0]                        req_bucket_0,
   input  logic [9:0]                        req_bucket_1,
   input  logic [9:0]                        req_bucket_2,
   input  logic [9:0]                        req_bucket_3,
   input  logic [dccm_pkg::AMOUNT_W-1:0]     req_amount,
   input  logic                              req_use_slot,
   input  logic [dccm_pkg::SLOT_W-1:0]       req_slot_decay,
   output logic [dccm_pkg::RATE_W-1:0]       rsp_rate,
   output logic                              rsp_rate_valid,
   output logic                              new_wr_en,
   output logic [COUNTER_BITS-1:0]           new_wr_data,
   output logic                              old_wr_en,
   output logic [COUNTER_BITS-1:0]           old_wr_data,
   output logic [HASH_BITS-1:0]              ram_addr,
   output logic                              ram_rd_en,
   input  logic [COUNTER_BITS-1:0]           new_rd_data,
   input  logic [COUNTER_BITS-1:0]           old_rd_data
);
   import dccm_pkg::*;

   localparam int LIM    = (MAX_HASHES < BUCKET_FIELDS) ? MAX_HASHES : BUCKET_FIELDS;
   localparam int SW     = ((COUNTER_BITS > 32) ? COUNTER_BITS : 32) + 1;
   localparam int OPA_W  = 2 * MUL_A_W;
   localparam int SUM_W  = MUL_P_W + 17;
   localparam logic [SLOT_W-1:0] ONE_Q16 = SLOT_W'(65536);

   logic [ALPHA_W-1:0]      alpha_ff;
   logic [SCALE_W-1:0]      scale_ff;
   logic [NHASH_W-1:0]      nhash_ff;
   logic [1:0]              cmd_ff;
   logic [HASH_BITS-1:0]    idx_ff [BUCKET_FIELDS];
   logic [AMOUNT_W-1:0]     amount_ff;
   logic                    slot_ff;
   logic [SLOT_W-1:0]       d_ff;
   logic [NHASH_W-1:0]      n_ff;
   logic [HASH_BITS-1:0]    scan_ff;
   logic [COUNTER_BITS-1:0] newmin_ff, oldmin_ff;
   logic [RATE_W-1:0]       rt0_ff, t1_ff, rate_ff;
   logic                    rvalid_ff;
   logic [MUL_P_W-1:0]      prod_ff, hi_ff;

   logic [NHASH_W-1:0]      n_in;
   logic [SW-1:0]           addsum;
   logic [COUNTER_BITS-1:0] addsat, diff;
   logic [OPA_W-1:0]        opa;
   logic [MUL_B_W-1:0]      opb;
   logic [MUL_A_W-1:0]      opa_half;
   logic [SUM_W-1:0]        sum;
   logic [RATE_W-1:0]       rate_res;
   logic [COUNTER_BITS-1:0] shrink_res;
   logic [RATE_W:0]         fin_sum;
   logic [RATE_W-1:0]       fin_sat;
   logic                    bump;

   always_comb begin
      n_in = nhash_ff;
      if (n_in == '0) n_in = NHASH_W'(1);
      if (n_in > NHASH_W'(LIM)) n_in = NHASH_W'(LIM);
   end

   assign addsum = SW'(newmin_ff) + SW'({amount_ff, 8'b0});
   assign addsat = (addsum > SW'({COUNTER_BITS{1'b1}})) ? {COUNTER_BITS{1'b1}}
                                                        : addsum[COUNTER_BITS-1:0];
   assign diff   = (newmin_ff > oldmin_ff) ? (newmin_ff - oldmin_ff) : '0;

   always_comb begin
      case (ctl.mul_sel)
         MSEL_RT0: begin
            opa = OPA_W'(oldmin_ff);
            opb = MUL_B_W'(scale_ff);
         end
         MSEL_T1: begin
            opa = OPA_W'(rt0_ff);
            opb = MUL_B_W'(d_ff);
         end
         MSEL_T2: begin
            opa = OPA_W'(diff);
            opb = MUL_B_W'(ONE_Q16 - d_ff);
         end
         default: begin
            opa = OPA_W'(new_rd_data);
            opb = MUL_B_W'(alpha_ff);
         end
      endcase
   end

   assign opa_half = ctl.mul_hi ? opa[OPA_W-1:MUL_A_W] : opa[MUL_A_W-1:0];

   assign sum = SUM_W'({hi_ff, 16'b0}) + SUM_W'(prod_ff[MUL_P_W-1:16]);
   assign rate_res = ((hi_ff[MUL_P_W-1:32] != '0) || sum[RATE_W]) ? {RATE_W{1'b1}}
                                                                  : sum[RATE_W-1:0];
   assign shrink_res = sum[COUNTER_BITS-1:0];
   assign fin_sum = {1'b0, t1_ff} + {1'b0, rate_res};
   assign fin_sat = fin_sum[RATE_W] ? {RATE_W{1'b1}} : fin_sum[RATE_W-1:0];

   assign ram_addr  = ctl.addr_scan ? scan_ff : idx_ff[ctl.k];
   assign ram_rd_en = ctl.rd_en;
   assign bump      = ctl.wr_bump && (new_rd_data < newmin_ff);
   assign new_wr_en = ctl.clear_wr || ctl.decay_wr || bump;
   assign old_wr_en = ctl.clear_wr || ctl.decay_wr;
   assign new_wr_data = ctl.clear_wr ? '0 : (ctl.decay_wr ? shrink_res : newmin_ff);
   assign old_wr_data = ctl.clear_wr ? '0 : shrink_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_W'(32768);
         scale_ff  <= SCALE_W'(65536);
         nhash_ff  <= NHASH_W'(4);
         scan_ff   <= '0;
         cmd_ff    <= CMD_NONE;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ALPHA: alpha_ff <= csr_wdata[ALPHA_W-1:0];
               CSR_SCALE: scale_ff <= csr_wdata[SCALE_W-1:0];
               CSR_NHASH: nhash_ff <= csr_wdata[NHASH_W-1:0];
               default: ;
            endcase
         end
         if (ctl.capture) begin
            cmd_ff    <= req_cmd;
            scan_ff   <= '0;
            rvalid_ff <= (req_cmd == CMD_ADD) || (req_cmd == CMD_CHECK);
         end else if (ctl.scan_inc) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         idx_ff[0] <= HASH_BITS'(req_bucket_0);
         idx_ff[1] <= HASH_BITS'(req_bucket_1);
         idx_ff[2] <= HASH_BITS'(req_bucket_2);
         idx_ff[3] <= HASH_BITS'(req_bucket_3);
         amount_ff <= req_amount;
         slot_ff   <= req_use_slot;
         d_ff      <= (req_slot_decay > ONE_Q16) ? ONE_Q16 : req_slot_decay;
         n_ff      <= n_in;
         rate_ff   <= '0;
      end
      if (ctl.min_upd) begin
         if ((ctl.k == '0) || (new_rd_data < newmin_ff)) newmin_ff <= new_rd_data;
         if ((ctl.k == '0) || (old_rd_data < oldmin_ff)) oldmin_ff <= old_rd_data;
      end
      if (ctl.add_amt) newmin_ff <= addsat;
      if (ctl.mul_hi || ctl.mul_lo) prod_ff <= opa_half * opb;
      if (ctl.mul_lo) hi_ff <= prod_ff;
      if (ctl.mul_sum) begin
         case (ctl.mul_sel)
            MSEL_RT0: begin
               rt0_ff  <= rate_res;
               rate_ff <= rate_res;
            end
            MSEL_T1: t1_ff   <= rate_res;
            MSEL_T2: rate_ff <= fin_sat;
            default: ;
         endcase
      end
   end

   assign sts.cmd       = cmd_ff;
   assign sts.use_slot  = slot_ff;
   assign sts.k_last    = ((NHASH_W'(ctl.k) + NHASH_W'(1)) == n_ff);
   assign sts.scan_last = (scan_ff == {HASH_BITS{1'b1}});

   assign rsp_rate       = rate_ff;
   assign rsp_rate_valid = rvalid_ff;
endmodule

// File: hw/rtl/decaying_conservative_count_min.sv
// Top level: decaying conservative-update count-min rate meter.
`timescale 1ns / 1ps
// After reset the block clears both counter tables, one entry per cycle, with
// busy high; configuration writes are taken during that time. A word is
// accepted when start is high and busy is low, and its result appears in the
// cycle after the work ends, for one cycle, with rsp_valid high; the receiver
// cannot stall it. An add or a check reads its buckets through the single
// read port per table and computes the rate on the shared 32x25 multiplier,
// which runs each product in two halves; use_slot adds two more products.
// A decay walks the table entry by entry, reading, scaling and writing back each.
module decaying_conservative_count_min #(
   parameter int HASH_BITS    = 10,
   parameter int MAX_HASHES   = 4,
   parameter int COUNTER_BITS = 40
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_cmd,
   input  logic [9:0]                       req_bucket_0,
   input  logic [9:0]                       req_bucket_1,
   input  logic [9:0]                       req_bucket_2,
   input  logic [9:0]                       req_bucket_3,
   input  logic [dccm_pkg::AMOUNT_W-1:0]    req_amount,
   input  logic                             req_use_slot,
   input  logic [dccm_pkg::SLOT_W-1:0]      req_slot_decay,
   output logic                             rsp_valid,
   output logic [dccm_pkg::RATE_W-1:0]      rsp_rate,
   output logic                             rsp_rate_valid,
   input  logic                             csr_wr_en,
   input  logic [dccm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dccm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dccm_pkg::*;

   ctl_cmd_type             ctl;
   dp_sts_type              sts;
   logic                    new_wr_en, old_wr_en, ram_rd_en;
   logic [COUNTER_BITS-1:0] new_wr_data, old_wr_data, new_rd_data, old_rd_data;
   logic [HASH_BITS-1:0]    ram_addr;

   dccm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   dccm_dp #(
      .HASH_BITS    (HASH_BITS),
      .MAX_HASHES   (MAX_HASHES),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_bucket_0   (req_bucket_0),
      .req_bucket_1   (req_bucket_1),
      .req_bucket_2   (req_bucket_2),
      .req_bucket_3   (req_bucket_3),
      .req_amount     (req_amount),
      .req_use_slot   (req_use_slot),
      .req_slot_decay (req_slot_decay),
      .rsp_rate       (rsp_rate),
      .rsp_rate_valid (rsp_rate_valid),
      .new_wr_en      (new_wr_en),
      .new_wr_data    (new_wr_data),
      .old_wr_en      (old_wr_en),
      .old_wr_data    (old_wr_data),
      .ram_addr       (ram_addr),
      .ram_rd_en      (ram_rd_en),
      .new_rd_data    (new_rd_data),
      .old_rd_data    (old_rd_data)
   );

   dccm_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (1 << HASH_BITS)
   ) u_new_ram (
      .clock   (clock),
      .wr_en   (new_wr_en),
      .wr_addr (ram_addr),
      .wr_data (new_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (new_rd_data)
   );

   dccm_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (1 << HASH_BITS)
   ) u_old_ram (
      .clock   (clock),
      .wr_en   (old_wr_en),
      .wr_addr (ram_addr),
      .wr_data (old_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (old_rd_data)
   );
endmodule
